### rtl/assert_macros.svh
// Assertion macros shared by the frame encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge outside reset.
`define DLECRC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("dlecrc assertion failed");
// Check that an antecedent implies a consequent in the same cycle.
`define DLECRC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dlecrc implication failed");
`else
`define DLECRC_ASSERT(lbl, prop)
`define DLECRC_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

### rtl/dlecrc_pkg.sv
// Shared types, symbol constants, slot codes and CRC helpers for the frame encoder.
package dlecrc_pkg;

	localparam logic [7:0]  SYM_SOH  = 8'h01;
	localparam logic [7:0]  SYM_EOT  = 8'h04;
	localparam logic [7:0]  SYM_DLE  = 8'h10;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	// Output slots of one word, in wire order
	localparam int          SLOT_W        = 3;
	localparam int          NUM_SLOTS     = 8;
	localparam logic [2:0]  SLOT_SOH      = 3'd0;
	localparam logic [2:0]  SLOT_DLE_DATA = 3'd1;
	localparam logic [2:0]  SLOT_DATA     = 3'd2;
	localparam logic [2:0]  SLOT_DLE_LO   = 3'd3;
	localparam logic [2:0]  SLOT_CRC_LO   = 3'd4;
	localparam logic [2:0]  SLOT_DLE_HI   = 3'd5;
	localparam logic [2:0]  SLOT_CRC_HI   = 3'd6;
	localparam logic [2:0]  SLOT_EOT      = 3'd7;

	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [15:0] crc;
	} item_t;

	// True for bytes that need a DLE in front of them
	function automatic logic needs_dle(input logic [7:0] b);
		return (b == SYM_SOH) || (b == SYM_EOT) || (b == SYM_DLE);
	endfunction

	// Fold one byte into the CRC, MSB first
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### rtl/dlecrc_framer.sv
// Word holding register, slot walker and output byte register of the frame encoder.
`include "assert_macros.svh"
module dlecrc_framer import dlecrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  item_t      item,
	output logic       load_ok,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_done
);

	item_t                item_s1;
	logic                 s1_valid_q;
	logic [SLOT_W-1:0]    slot_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic                 run_last_q;
	logic                 frame_done_q;

	logic [NUM_SLOTS-1:0] mask;
	logic [NUM_SLOTS-1:0] above;
	logic [SLOT_W-1:0]    next_slot;
	logic [SLOT_W-1:0]    start_slot;
	logic                 final_slot;
	logic                 emit;
	logic [7:0]           slot_byte;

	// Mark the slots this word sends
	always_comb begin
		mask                = '0;
		mask[SLOT_SOH]      = item_s1.first;
		mask[SLOT_DLE_DATA] = needs_dle(item_s1.data);
		mask[SLOT_DATA]     = 1'b1;
		mask[SLOT_DLE_LO]   = item_s1.last && needs_dle(item_s1.crc[7:0]);
		mask[SLOT_CRC_LO]   = item_s1.last;
		mask[SLOT_DLE_HI]   = item_s1.last && needs_dle(item_s1.crc[15:8]);
		mask[SLOT_CRC_HI]   = item_s1.last;
		mask[SLOT_EOT]      = item_s1.last;
	end

	// Find the next enabled slot after the current one
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			above[i] = mask[i] && (SLOT_W'(i) > slot_q);
		end
		next_slot = slot_q;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (above[i]) begin
				next_slot = SLOT_W'(i);
			end
		end
		final_slot = (above == '0);
	end

	// Pick the opening slot of an incoming word
	always_comb begin
		if (item.first) begin
			start_slot = SLOT_SOH;
		end else if (needs_dle(item.data)) begin
			start_slot = SLOT_DLE_DATA;
		end else begin
			start_slot = SLOT_DATA;
		end
	end

	// Decode the byte of the current slot
	always_comb begin
		unique case (slot_q)
			SLOT_SOH:      slot_byte = SYM_SOH;
			SLOT_DLE_DATA: slot_byte = SYM_DLE;
			SLOT_DATA:     slot_byte = item_s1.data;
			SLOT_DLE_LO:   slot_byte = SYM_DLE;
			SLOT_CRC_LO:   slot_byte = item_s1.crc[7:0];
			SLOT_DLE_HI:   slot_byte = SYM_DLE;
			SLOT_CRC_HI:   slot_byte = item_s1.crc[15:8];
			SLOT_EOT:      slot_byte = SYM_EOT;
			default:       slot_byte = SYM_EOT;
		endcase
	end

	assign emit    = s1_valid_q && (!out_valid_q || out_ready);
	assign load_ok = !s1_valid_q || (emit && final_slot);

	// Hold the word and advance through its slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			slot_q     <= SLOT_SOH;
		end else begin
			if (load) begin
				s1_valid_q <= 1'b1;
				slot_q     <= start_slot;
			end else if (emit) begin
				if (final_slot) begin
					s1_valid_q <= 1'b0;
				end else begin
					slot_q <= next_slot;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

	// Output register: fill on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q   <= slot_byte;
			run_last_q   <= final_slot;
			frame_done_q <= (slot_q == SLOT_EOT);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_last   = run_last_q;
	assign frame_done = frame_done_q;

	`DLECRC_ASSERT_IMP(a_slot_enabled, s1_valid_q, mask[slot_q])
	`DLECRC_ASSERT_IMP(a_done_is_last, out_valid_q && frame_done_q, run_last_q)
	`DLECRC_ASSERT_IMP(a_done_is_eot, out_valid_q && frame_done_q, out_byte_q == SYM_EOT)

endmodule

### rtl/dle_stuffed_frame_crc16_encoder_core.sv
// Top level of the DLE-stuffed SOH/EOT frame encoder with CRC-16.
// Each input word is a frame byte flagged first and/or last. A first byte is
// preceded by SOH and restarts the CRC-16 (poly 0x1021, init 0, MSB first);
// SOH, EOT and DLE bytes go out behind a DLE; a last byte is followed by the
// stuffed CRC low byte, the stuffed CRC high byte and EOT, with frame_done on
// the EOT. run_last marks the final output byte caused by each input word.
// The block sends one output byte per cycle while out_ready stays high,
// through a single output register; a word makes 1 to 8 bytes. The next
// word is taken in the same cycle as the final byte of the current one moves
// into the output register, so words follow without gaps.
`include "assert_macros.svh"
module dle_stuffed_frame_crc16_encoder_core import dlecrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       is_first,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_done
);

	logic [15:0] crc_q;
	logic [15:0] crc_base;
	logic [15:0] crc_next;
	logic        load;
	item_t       item;

	// Restart the CRC on a first byte, then fold the byte in
	assign crc_base = is_first ? 16'h0000 : crc_q;
	assign crc_next = crc_fold(crc_base, data_byte);
	assign load     = in_valid && in_ready;

	always_comb begin
		item.data  = data_byte;
		item.first = is_first;
		item.last  = is_last;
		item.crc   = crc_next;
	end

	// Hold the running CRC between words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 16'h0000;
		end else if (load) begin
			crc_q <= crc_next;
		end
	end

	dlecrc_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.item       (item),
		.load_ok    (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.frame_done (frame_done)
	);

	`DLECRC_ASSERT(a_crc_restart, (load && is_first) |=> (crc_q == crc_fold(16'h0000, $past(data_byte))))
	`DLECRC_ASSERT(a_crc_hold, !load |=> $stable(crc_q))
	`DLECRC_ASSERT(a_out_after_load, (load && !out_valid) |-> ##[1:2] out_valid)

endmodule

### test/tb_dle_stuffed_frame_crc16_encoder_core.sv
// Self-checking testbench for the DLE-stuffed SOH/EOT frame encoder with CRC-16.
module tb_dle_stuffed_frame_crc16_encoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	import dlecrc_pkg::*;

	typedef struct packed {
		logic [7:0] wire_val;
		logic       run_last;
		logic       frame_done;
	} wire_byte_t;

	// Predict the wire bytes of each accepted word and check them in order
	class frame_scoreboard;
		wire_byte_t  wire_fifo[$];
		logic [15:0] frame_crc;
		int          errors;

		function new();
			frame_crc = 16'h0000;
			errors = 0;
		endfunction

		// Fold one byte into a CRC-16, polynomial 0x1021, MSB first
		static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
			logic [15:0] c;
			c = crc ^ {b, 8'h00};
			for (int k = 0; k < 8; k++) begin
				c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
			end
			return c;
		endfunction

		static function bit is_special(logic [7:0] b);
			return b == SYM_SOH || b == SYM_EOT || b == SYM_DLE;
		endfunction

		static function void add_stuffed(ref wire_byte_t run[$], input logic [7:0] b);
			if (is_special(b)) begin
				run.push_back('{SYM_DLE, 1'b0, 1'b0});
			end
			run.push_back('{b, 1'b0, 1'b0});
		endfunction

		function void note_word(logic [7:0] d, logic f, logic l);
			wire_byte_t run[$];
			wire_byte_t w;
			if (f) begin
				run.push_back('{SYM_SOH, 1'b0, 1'b0});
				frame_crc = 16'h0000;
			end
			add_stuffed(run, d);
			frame_crc = crc_step(frame_crc, d);
			if (l) begin
				add_stuffed(run, frame_crc[7:0]);
				add_stuffed(run, frame_crc[15:8]);
				run.push_back('{SYM_EOT, 1'b0, 1'b1});
			end
			// Mark the closing byte of this word
			for (int i = 0; i < run.size(); i++) begin
				w = run[i];
				w.run_last = (i == run.size() - 1);
				wire_fifo.push_back(w);
			end
		endfunction

		function void check_byte(logic [7:0] b, logic rl, logic fd);
			wire_byte_t exp_b;
			if (wire_fifo.size() == 0) begin
				$error("unexpected output byte 0x%02h", b);
				errors++;
				return;
			end
			exp_b = wire_fifo.pop_front();
			if (b !== exp_b.wire_val) begin
				$error("out_byte: expected 0x%02h, got 0x%02h", exp_b.wire_val, b);
				errors++;
			end
			if (rl !== exp_b.run_last) begin
				$error("run_last: expected %0b, got %0b", exp_b.run_last, rl);
				errors++;
			end
			if (fd !== exp_b.frame_done) begin
				$error("frame_done: expected %0b, got %0b", exp_b.frame_done, fd);
				errors++;
			end
		endfunction

		function int pending();
			return wire_fifo.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       is_first = 1'b0;
	logic       is_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_done;

	frame_scoreboard sb = new();
	int  burst_left = 0;
	int  words_in = 0;
	bit  rx_hold_req = 1'b0;

	dle_stuffed_frame_crc16_encoder_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.is_first   (is_first),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.frame_done (frame_done)
	);

	always #5 clk = ~clk;

	// Offer one word, hold it until taken, then continue the burst or idle
	task automatic send_word(logic [7:0] d, logic f, logic l);
		int gap;
		in_valid  <= 1'b1;
		data_byte <= d;
		is_first  <= f;
		is_last   <= l;
		do @(posedge clk); while (!in_ready);
		sb.note_word(d, f, l);
		words_in++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 15);
		end
	endtask

	// Stop offering until every predicted byte has come out
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Lean towards the stuffed symbols and the byte extremes
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return SYM_SOH;
			1: return SYM_EOT;
			2: return SYM_DLE;
			3: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_frame(int len);
		for (int i = 0; i < len; i++) begin
			send_word(pick_byte(), i == 0, i == len - 1);
		end
	endtask

	// Receiver: check each taken byte, then choose the next ready level
	initial begin
		int rx_mode;
		int rx_cycle;
		int hold_cnt;
		bit rdy;
		rx_mode = 0;
		rx_cycle = 0;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				sb.check_byte(out_byte, run_last, frame_done);
			end
			rx_cycle++;
			if (rx_cycle % 50 == 0) begin
				rx_mode = $urandom_range(0, 3);
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				rdy = 1'b0;
			end else if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_cnt = 300;
				rdy = 1'b0;
			end else begin
				case (rx_mode)
					0: rdy = 1'b1;
					1: rdy = $urandom_range(0, 1);
					2: rdy = (rx_cycle % 4 == 0);
					default: rdy = ($urandom_range(0, 4) != 0);
				endcase
			end
			out_ready <= rdy;
		end
	end

	// Stimulus
	initial begin
		logic [15:0] crc;
		logic [15:0] lo_hit;
		logic [15:0] hi_hit;
		bit          lo_found;
		bit          hi_found;
		bit          hold_done;
		bit          pause_done;
		int          len;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Frame of special and extreme bytes
		send_word(8'h01, 1'b1, 1'b0);
		send_word(8'h04, 1'b0, 1'b0);
		send_word(8'h10, 1'b0, 1'b0);
		send_word(8'h00, 1'b0, 1'b0);
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(8'h0F, 1'b0, 1'b0);
		send_word(8'h11, 1'b0, 1'b1);
		// Frames holding a single byte
		send_word(8'h10, 1'b1, 1'b1);
		send_word(8'hAA, 1'b1, 1'b1);
		send_word(8'h00, 1'b1, 1'b1);
		send_word(8'hFF, 1'b1, 1'b1);
		// Bytes with no frame open, the CRC carried over from the closed frame
		send_word(8'h04, 1'b0, 1'b0);
		send_word(8'h55, 1'b0, 1'b1);

		// Find two-byte frames whose CRC low or high byte needs stuffing
		lo_found = 1'b0;
		hi_found = 1'b0;
		lo_hit = 16'h0000;
		hi_hit = 16'h0000;
		for (int x = 0; x < 65536; x++) begin
			crc = frame_scoreboard::crc_step(16'h0000, x[15:8]);
			crc = frame_scoreboard::crc_step(crc, x[7:0]);
			if (!lo_found && frame_scoreboard::is_special(crc[7:0])) begin
				lo_found = 1'b1;
				lo_hit = x[15:0];
			end
			if (!hi_found && frame_scoreboard::is_special(crc[15:8])) begin
				hi_found = 1'b1;
				hi_hit = x[15:0];
			end
		end
		send_word(lo_hit[15:8], 1'b1, 1'b0);
		send_word(lo_hit[7:0], 1'b0, 1'b1);
		send_word(hi_hit[15:8], 1'b1, 1'b0);
		send_word(hi_hit[7:0], 1'b0, 1'b1);
		drain();

		// Random frames, with some loose words and broken frames as noise
		hold_done = 1'b0;
		pause_done = 1'b0;
		while (words_in < 225) begin
			if (!hold_done && words_in >= 90) begin
				hold_done = 1'b1;
				rx_hold_req = 1'b1;
			end
			if (!pause_done && words_in >= 170) begin
				pause_done = 1'b1;
				drain();
			end
			if ($urandom_range(0, 9) == 0) begin
				send_word(pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12)
					: $urandom_range(1, 6);
				send_frame(len);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("tb_dle_stuffed_frame_crc16_encoder_core passed");
		end else begin
			$display("tb_dle_stuffed_frame_crc16_encoder_core failed");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#2000000;
		$display("tb_dle_stuffed_frame_crc16_encoder_core failed");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/dlecrc_pkg.sv
rtl/dlecrc_framer.sv
rtl/dle_stuffed_frame_crc16_encoder_core.sv
test/tb_dle_stuffed_frame_crc16_encoder_core.sv
